### rtl/pfdm_pkg.sv
// Package for the PWM frequency / duty meter.
// Field widths, fixed constants and the flag struct shared by the meter modules.
// No dependencies.
package pfdm_pkg;

    localparam int CLK_W   = 27;   // reference clock rate field
    localparam int DUTY_W  = 14;   // duty cycle in 0.01 % units
    localparam int TICK_W  = 16;   // reported tick counts

    localparam logic [CLK_W-1:0]  CLK_RESET  = 27'd8000000;
    localparam logic [TICK_W-1:0] TICK_SAT   = 16'hFFFF;
    localparam int                DUTY_SCALE = 10000;

    // Control flags of one finished capture travelling front -> queue -> back.
    typedef struct packed {
        logic valid;
        logic wrap;
    } t_flag;

endpackage

### rtl/pfdm_front.sv
// Front end of the meter: tick counter, edge detection and capture sequencing.
// Depends on pfdm_pkg (t_flag). Pushes one capture record per completed measurement.
module pfdm_front #(
    parameter int CW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_start_req,
    input  logic                 i_signal_level,
    input  logic                 i_push_ready,
    output pfdm_pkg::t_flag      o_push,
    output logic [CW-1:0]        o_high,
    output logic [CW-1:0]        o_period
);

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_RISE1 = 4'b0010,
        PH_FALL  = 4'b0100,
        PH_RISE2 = 4'b1000
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [CW-1:0] r_tick, n_tick;
    logic [CW-1:0] r_rise, n_rise;
    logic [CW-1:0] r_fall, n_fall;
    logic          r_prev, n_prev;

    logic w_accept;
    logic w_rising;
    logic w_falling;

    assign o_ready   = i_push_ready;
    assign w_accept  = i_valid && o_ready;
    assign w_rising  = !r_prev && i_signal_level;
    assign w_falling = r_prev && !i_signal_level;

    // Interval math is done on the stamps as they stand; a wrap shows as non-increasing.
    assign o_high   = r_fall - r_rise;
    assign o_period = r_tick - r_rise;

    always_comb begin
        n_phase      = r_phase;
        n_tick       = r_tick;
        n_rise       = r_rise;
        n_fall       = r_fall;
        n_prev       = r_prev;
        o_push.valid = 1'b0;
        o_push.wrap  = !((r_rise < r_fall) && (r_fall < r_tick));
        if (w_accept) begin
            if (i_start_req) begin
                n_tick  = '0;
                n_prev  = i_signal_level;
                n_phase = PH_RISE1;
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                    end
                    PH_RISE1: begin
                        if (w_rising) begin
                            n_rise  = r_tick;
                            n_phase = PH_FALL;
                        end
                    end
                    PH_FALL: begin
                        if (w_falling) begin
                            n_fall  = r_tick;
                            n_phase = PH_RISE2;
                        end
                    end
                    PH_RISE2: begin
                        if (w_rising) begin
                            o_push.valid = 1'b1;
                            n_phase      = PH_IDLE;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
                n_prev = i_signal_level;
                n_tick = r_tick + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_rise  <= '0;
            r_fall  <= '0;
            r_prev  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_rise  <= n_rise;
            r_fall  <= n_fall;
            r_prev  <= n_prev;
        end
    end

endmodule

### rtl/pfdm_queue.sv
// Two-entry queue of capture records between the front end and the divider back end.
// Depends on pfdm_pkg (t_flag).
module pfdm_queue #(
    parameter int CW = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pfdm_pkg::t_flag i_push,
    input  logic [CW-1:0]   i_high,
    input  logic [CW-1:0]   i_period,
    output logic            o_push_ready,
    output pfdm_pkg::t_flag o_head,
    output logic [CW-1:0]   o_high,
    output logic [CW-1:0]   o_period,
    input  logic            i_pop
);

    localparam int DEPTH = 2;

    logic [CW-1:0] r_high   [DEPTH];
    logic [CW-1:0] r_period [DEPTH];
    logic          r_wrap   [DEPTH];
    logic          r_wptr;
    logic          r_rptr;
    logic [1:0]    r_count;

    logic w_push;
    logic w_pop;

    assign o_push_ready = (r_count != 2'(DEPTH));
    assign w_push       = i_push.valid && o_push_ready;
    assign w_pop        = i_pop && (r_count != 2'd0);

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.wrap  = r_wrap[r_rptr];
    assign o_high       = r_high[r_rptr];
    assign o_period     = r_period[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_high[r_wptr]   <= i_high;
            r_period[r_wptr] <= i_period;
            r_wrap[r_wptr]   <= i_push.wrap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (w_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/pfdm_back.sv
// Back end of the meter: shared restoring divider for frequency and duty, result register.
// Depends on pfdm_pkg (widths, constants, t_flag).
module pfdm_back #(
    parameter int CW = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [pfdm_pkg::CLK_W-1:0]   i_ref_clock_hz,
    input  pfdm_pkg::t_flag              i_head,
    input  logic [CW-1:0]                i_high,
    input  logic [CW-1:0]                i_period,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [pfdm_pkg::CLK_W-1:0]   o_frequency_hz,
    output logic [pfdm_pkg::DUTY_W-1:0]  o_duty_hundredths,
    output logic [pfdm_pkg::TICK_W-1:0]  o_high_ticks,
    output logic [pfdm_pkg::TICK_W-1:0]  o_period_ticks,
    output logic                         o_status
);

    // Dividend width covers both the clock rate and high * 10000.
    localparam int DW    = (pfdm_pkg::CLK_W > CW + 14) ? pfdm_pkg::CLK_W : CW + 14;
    localparam int CNT_W = $clog2(DW);
    localparam int XW    = (CW > pfdm_pkg::TICK_W) ? CW : pfdm_pkg::TICK_W;

    typedef enum logic [3:0] {
        BS_IDLE = 4'b0001,
        BS_FREQ = 4'b0010,
        BS_DUTY = 4'b0100,
        BS_OUT  = 4'b1000
    } t_bstate;

    t_bstate          r_state;
    logic [DW-1:0]    r_dq;
    logic [CW-1:0]    r_rem;
    logic [CW-1:0]    r_div;
    logic [DW-1:0]    r_num;
    logic [CNT_W-1:0] r_cnt;

    logic [pfdm_pkg::CLK_W-1:0]  r_freq;
    logic [pfdm_pkg::DUTY_W-1:0] r_duty;
    logic [pfdm_pkg::TICK_W-1:0] r_high_ticks;
    logic [pfdm_pkg::TICK_W-1:0] r_period_ticks;
    logic                        r_status;

    logic [CW:0]     w_shift;
    logic            w_ge;
    logic [CW:0]     w_diff;
    logic [CW-1:0]   w_rem_next;
    logic            w_last;
    logic [XW-1:0]   w_high_x;
    logic [XW-1:0]   w_period_x;
    logic [pfdm_pkg::TICK_W-1:0] w_high_sat;
    logic [pfdm_pkg::TICK_W-1:0] w_period_sat;

    // One restoring division step per cycle.
    assign w_shift    = {r_rem, r_dq[DW-1]};
    assign w_ge       = (w_shift >= {1'b0, r_div});
    assign w_diff     = w_shift - {1'b0, r_div};
    assign w_rem_next = w_ge ? w_diff[CW-1:0] : w_shift[CW-1:0];
    assign w_last     = (r_cnt == CNT_W'(DW - 1));

    assign w_high_x     = XW'(i_high);
    assign w_period_x   = XW'(i_period);
    assign w_high_sat   = (w_high_x > XW'(pfdm_pkg::TICK_SAT)) ? pfdm_pkg::TICK_SAT
                                                               : w_high_x[15:0];
    assign w_period_sat = (w_period_x > XW'(pfdm_pkg::TICK_SAT)) ? pfdm_pkg::TICK_SAT
                                                                 : w_period_x[15:0];

    assign o_pop             = (r_state == BS_IDLE) && i_head.valid;
    assign o_valid           = (r_state == BS_OUT);
    assign o_frequency_hz    = r_freq;
    assign o_duty_hundredths = r_duty;
    assign o_high_ticks      = r_high_ticks;
    assign o_period_ticks    = r_period_ticks;
    assign o_status          = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            unique case (r_state)
                BS_IDLE: begin
                    if (i_head.valid) begin
                        r_state <= i_head.wrap ? BS_OUT : BS_FREQ;
                    end
                end
                BS_FREQ: begin
                    if (w_last) begin
                        r_state <= BS_DUTY;
                    end
                end
                BS_DUTY: begin
                    if (w_last) begin
                        r_state <= BS_OUT;
                    end
                end
                BS_OUT: begin
                    if (i_ready) begin
                        r_state <= BS_IDLE;
                    end
                end
                default: r_state <= BS_IDLE;
            endcase
        end
    end

    // Datapath: load on pop, iterate, then hold the result until it is taken.
    always_ff @(posedge i_clk) begin
        case (r_state)
            BS_IDLE: begin
                r_dq   <= DW'(i_ref_clock_hz);
                r_rem  <= '0;
                r_cnt  <= '0;
                r_div  <= i_period;
                r_num  <= DW'(i_high) * DW'(pfdm_pkg::DUTY_SCALE);
                if (i_head.wrap) begin
                    r_freq         <= '0;
                    r_duty         <= '0;
                    r_high_ticks   <= '0;
                    r_period_ticks <= '0;
                    r_status       <= 1'b1;
                end else begin
                    r_high_ticks   <= w_high_sat;
                    r_period_ticks <= w_period_sat;
                    r_status       <= 1'b0;
                end
            end
            BS_FREQ: begin
                if (w_last) begin
                    r_freq <= r_dq[DW-2:0] == '0 && !w_ge ? '0
                            : pfdm_pkg::CLK_W'({r_dq[DW-2:0], w_ge});
                    r_dq   <= r_num;
                    r_rem  <= '0;
                    r_cnt  <= '0;
                end else begin
                    r_dq  <= {r_dq[DW-2:0], w_ge};
                    r_rem <= w_rem_next;
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
            BS_DUTY: begin
                r_dq  <= {r_dq[DW-2:0], w_ge};
                r_rem <= w_rem_next;
                r_cnt <= r_cnt + CNT_W'(1);
                if (w_last) begin
                    r_duty <= pfdm_pkg::DUTY_W'({r_dq[DW-2:0], w_ge});
                end
            end
            default: begin
            end
        endcase
    end

endmodule

### rtl/pwm_frequency_duty_meter.sv
// Top level of the PWM frequency / duty meter.
// Depends on pfdm_pkg, pfdm_front, pfdm_queue and pfdm_back.
//
//   Channel   Direction  Handshake                  Payload
//   -------   ---------  -------------------------  ------------------------------------
//   in        sink       i_in_valid / o_in_ready    i_start_req, i_signal_level
//   out       source     o_out_valid / i_out_ready  o_frequency_hz, o_duty_hundredths,
//                                                   o_high_ticks, o_period_ticks, o_status
//   cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_ref_clock_hz
//
// The front end takes one tick per clock while the capture queue has room.
// Each finished measurement then passes through the shared restoring divider of the back
// end (DW = max(27, COUNT_WIDTH+14)), one quotient bit per cycle, followed by the handoff
// of the result register. A wrapped measurement skips the divider.
// Reset (synchronous, active low) idles the meter, zeroes the tick counter and stamps,
// empties the queue and loads the clock rate register with 8000000.
// Stalls: a held result stalls the divider; a full two-entry queue holds o_in_ready low.
module pwm_frequency_duty_meter #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input ticks
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_start_req,
    input  logic                         i_signal_level,
    // results
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [pfdm_pkg::CLK_W-1:0]   o_frequency_hz,
    output logic [pfdm_pkg::DUTY_W-1:0]  o_duty_hundredths,
    output logic [pfdm_pkg::TICK_W-1:0]  o_high_ticks,
    output logic [pfdm_pkg::TICK_W-1:0]  o_period_ticks,
    output logic                         o_status,
    // clock rate register
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [pfdm_pkg::CLK_W-1:0]   i_cfg_ref_clock_hz
);

    logic [pfdm_pkg::CLK_W-1:0] r_ref_clock_hz;

    pfdm_pkg::t_flag        w_push;
    logic                   w_push_ready;
    logic [COUNT_WIDTH-1:0] w_push_high;
    logic [COUNT_WIDTH-1:0] w_push_period;
    pfdm_pkg::t_flag        w_head;
    logic [COUNT_WIDTH-1:0] w_head_high;
    logic [COUNT_WIDTH-1:0] w_head_period;
    logic                   w_pop;

    // The register is always writable. The back end reads it when it takes a capture,
    // so write it only while no measurement is in flight.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_clock_hz <= pfdm_pkg::CLK_RESET;
        end else if (i_cfg_valid) begin
            r_ref_clock_hz <= i_cfg_ref_clock_hz;
        end
    end

    // Front end: count ticks, detect edges, stamp them and push a record per measurement.
    pfdm_front #(
        .CW (COUNT_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_start_req    (i_start_req),
        .i_signal_level (i_signal_level),
        .i_push_ready   (w_push_ready),
        .o_push         (w_push),
        .o_high         (w_push_high),
        .o_period       (w_push_period)
    );

    // Short queue decouples per-tick capture from the slow divider.
    pfdm_queue #(
        .CW (COUNT_WIDTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_high       (w_push_high),
        .i_period     (w_push_period),
        .o_push_ready (w_push_ready),
        .o_head       (w_head),
        .o_high       (w_head_high),
        .o_period     (w_head_period),
        .i_pop        (w_pop)
    );

    // Back end: frequency = clock / period, duty = high * 10000 / period, then hold.
    pfdm_back #(
        .CW (COUNT_WIDTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ref_clock_hz    (r_ref_clock_hz),
        .i_head            (w_head),
        .i_high            (w_head_high),
        .i_period          (w_head_period),
        .o_pop             (w_pop),
        .o_valid           (o_out_valid),
        .i_ready           (i_out_ready),
        .o_frequency_hz    (o_frequency_hz),
        .o_duty_hundredths (o_duty_hundredths),
        .o_high_ticks      (o_high_ticks),
        .o_period_ticks    (o_period_ticks),
        .o_status          (o_status)
    );

    // A wrapped measurement carries no numbers.
    a_wrap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_frequency_hz == '0 && o_duty_hundredths == '0
                                    && o_high_ticks == '0 && o_period_ticks == '0)
        else $error("wrap result carries nonzero fields");

    // High time is always shorter than the period, so duty stays at or below 100 %.
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_status |-> o_duty_hundredths <= 14'd10000)
        else $error("duty above 100 percent");

    // A good measurement spans at least two ticks and high time never exceeds it.
    a_period_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_status |-> o_period_ticks >= 16'd2
                                     && o_high_ticks <= o_period_ticks)
        else $error("period or high time out of order");

endmodule
